[hdl/clcd_pkg.sv]
package clcd_pkg;

    localparam int DEF_ROWS    = 2;
    localparam int DEF_COLS    = 16;
    localparam int MAX_RESULTS = 50;

    localparam logic [7:0] BLANK_RESET = 8'hA0;
    localparam logic [7:0] DEV_RESET   = 8'h74;

    localparam logic [7:0] CODE_DOLLAR = 8'h82;
    localparam logic [7:0] CODE_AT     = 8'hC0;
    localparam logic [7:0] CODE_PUNCT  = 8'hA1;
    localparam logic [7:0] CODE_LOWER  = 8'hE1;

    localparam logic [7:0] CTRL_CMD    = 8'h00;
    localparam logic [7:0] CTRL_DATA   = 8'h40;
    localparam logic [7:0] DDRAM_BASE  = 8'h80;
    localparam logic [7:0] SETUP_FUNC  = 8'h3E;
    localparam logic [7:0] SETUP_DISP  = 8'h0C;
    localparam logic [7:0] SETUP_ENTRY = 8'h06;
    localparam logic [7:0] SETUP_LAST  = 8'hA0;

    typedef enum logic [2:0] {
        ACT_INIT  = 3'd0,
        ACT_CLEAR = 3'd1,
        ACT_GOTO  = 3'd2,
        ACT_PRINT = 3'd3,
        ACT_RAW   = 3'd4
    } action_t;

    typedef enum logic {
        REG_BLANK  = 1'b0,
        REG_DEVICE = 1'b1
    } cfg_reg_t;

    function automatic logic [7:0] map_char(input logic [7:0] ch, input logic [7:0] blank);
        logic [7:0] code;
        code = blank;
        if (ch == 8'h24) begin
            code = CODE_DOLLAR;
        end else if (ch == 8'h40) begin
            code = CODE_AT;
        end else if (ch >= 8'h21 && ch <= 8'h5A) begin
            code = ch - 8'h21 + CODE_PUNCT;
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            code = ch - 8'h61 + CODE_LOWER;
        end
        return code;
    endfunction

endpackage

[hdl/clcd_store.sv]
module clcd_store #(
    parameter int DEPTH  = clcd_pkg::DEF_ROWS * clcd_pkg::DEF_COLS,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clr,
    input  logic [7:0]        clr_value,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       fill_reg;
    logic [7:0]       fill_rd_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            fill_reg     <= clcd_pkg::BLANK_RESET;
            fill_rd_reg  <= clcd_pkg::BLANK_RESET;
            rd_valid_reg <= 1'b0;
        end else begin
            if (clr) begin
                valid_reg <= '0;
                fill_reg  <= clr_value;
            end else if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
                fill_rd_reg  <= fill_reg;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : fill_rd_reg;

endmodule

[hdl/char_lcd_frame_buffer_i2c.sv]
// Character LCD frame buffer that turns screen actions into I2C bus bytes. Each input
// transfer carries one action (init, clear, goto, print char, raw char); each output
// transfer carries one bus byte with its start and stop flags, and tlast marks the final
// byte caused by that input. Clear, goto and a print char without tlast produce nothing.
// Init, a print char with tlast and an in-range raw char produce a stream of bytes, one
// per cycle while m_tready stays high: init gives 6 + ROWS*(COLS+5) bytes, a refresh
// ROWS*(COLS+5), a raw char ROWS*(COLS+5) + 6, and no action gives more than fifty.
// The byte sequencer is the limit: it walks the screen store through its single read
// port one cell per cycle while m_tready stays high and accepts the next input only
// after the last byte of the current one has been issued. Configuration
// writes are taken in any cycle and should only be made while no output is pending.
module char_lcd_frame_buffer_i2c #(
    parameter int ROWS = clcd_pkg::DEF_ROWS,
    parameter int COLS = clcd_pkg::DEF_COLS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // row, col, char_code, zero padding
    input  logic [2:0]  s_tuser,   // action
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // bus_byte
    output logic [1:0]  m_tuser,   // start_before, stop_after
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int DEPTH  = ROWS * COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int STEP_W = $clog2(COLS + 5);
    localparam int CNT_W  = $clog2(clcd_pkg::MAX_RESULTS + 1);

    localparam logic [2:0]        ROW_LIM   = 3'(ROWS);
    localparam logic [5:0]        COL_LIM   = 6'(COLS);
    localparam logic [STEP_W-1:0] STEP_HDR  = STEP_W'(5);
    localparam logic [STEP_W-1:0] STEP_END  = STEP_W'(COLS + 4);
    localparam logic [CNT_W-1:0]  CNT_FINAL = CNT_W'(clcd_pkg::MAX_RESULTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_REFRESH,
        ST_CELL
    } state_t;

    state_t             state_reg;
    logic [ROW_W-1:0]   cursor_row_reg;
    logic [COL_W-1:0]   cursor_col_reg;
    logic [7:0]         blank_reg;
    logic [7:0]         device_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [ROW_W-1:0]   seq_row_reg;
    logic [ROW_W-1:0]   tgt_row_reg;
    logic [COL_W-1:0]   tgt_col_reg;
    logic               do_cell_reg;
    logic [CNT_W-1:0]   res_cnt_reg;
    logic               m_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               out_cell_reg;
    logic               out_start_reg;
    logic               out_stop_reg;
    logic               out_last_reg;

    logic [1:0]          in_row;
    logic [4:0]          in_col;
    logic [7:0]          in_char;
    clcd_pkg::action_t   in_action;
    logic                in_accept;
    logic                in_range;

    logic [ADDR_W-1:0]  cursor_addr;
    logic [ADDR_W-1:0]  target_addr;
    logic [ADDR_W-1:0]  row_base;
    logic [7:0]         row_code;
    logic               gen_go;
    logic [7:0]         gen_byte;
    logic               gen_start;
    logic               gen_stop;
    logic               gen_cell;
    logic               gen_end;
    logic               gen_last;
    logic [ADDR_W-1:0]  gen_addr;

    logic               st_clr;
    logic               st_wr_en;
    logic [ADDR_W-1:0]  st_wr_addr;
    logic [7:0]         st_wr_data;
    logic [7:0]         st_rd_data;

    assign in_row    = s_tdata[1:0];
    assign in_col    = s_tdata[6:2];
    assign in_char   = s_tdata[14:7];
    assign in_action = clcd_pkg::action_t'(s_tuser);

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_range  = ({1'b0, in_row} < ROW_LIM) && ({1'b0, in_col} < COL_LIM);
    assign cfg_ready = 1'b1;

    assign cursor_addr = ADDR_W'(int'(cursor_row_reg) * COLS + int'(cursor_col_reg));
    assign target_addr = ADDR_W'(int'(in_row) * COLS + int'(in_col));
    assign row_base    = ADDR_W'(int'(seq_row_reg) * COLS);
    assign row_code    = clcd_pkg::DDRAM_BASE | ((8'(seq_row_reg) + 8'd1) << 5);

    always_comb begin
        gen_byte  = '0;
        gen_start = 1'b0;
        gen_stop  = 1'b0;
        gen_cell  = 1'b0;
        gen_end   = 1'b0;
        gen_addr  = '0;
        unique case (state_reg) inside
            ST_INIT: begin
                case (step_reg)
                    STEP_W'(0): begin
                        gen_byte  = device_reg;
                        gen_start = 1'b1;
                    end
                    STEP_W'(1): gen_byte = clcd_pkg::CTRL_CMD;
                    STEP_W'(2): gen_byte = clcd_pkg::SETUP_FUNC;
                    STEP_W'(3): gen_byte = clcd_pkg::SETUP_DISP;
                    STEP_W'(4): gen_byte = clcd_pkg::SETUP_ENTRY;
                    default: begin
                        gen_byte = clcd_pkg::SETUP_LAST;
                        gen_stop = 1'b1;
                    end
                endcase
            end
            ST_REFRESH, ST_CELL: begin
                case (step_reg) inside
                    STEP_W'(0), STEP_W'(3): begin
                        gen_byte  = device_reg;
                        gen_start = 1'b1;
                    end
                    STEP_W'(1): gen_byte = clcd_pkg::CTRL_CMD;
                    STEP_W'(2): begin
                        gen_byte = (state_reg == ST_CELL) ? row_code + 8'(tgt_col_reg)
                                                          : row_code;
                        gen_stop = 1'b1;
                    end
                    STEP_W'(4): gen_byte = clcd_pkg::CTRL_DATA;
                    default: begin
                        gen_cell = 1'b1;
                        if (state_reg == ST_CELL) begin
                            gen_addr = row_base + ADDR_W'(tgt_col_reg);
                            gen_stop = 1'b1;
                            gen_end  = 1'b1;
                        end else begin
                            gen_addr = row_base + ADDR_W'(step_reg - STEP_HDR);
                            gen_stop = (step_reg == STEP_END);
                            gen_end  = gen_stop && !do_cell_reg
                                       && (seq_row_reg == ROW_W'(ROWS - 1));
                        end
                    end
                endcase
            end
            default: begin
                gen_byte = '0;
            end
        endcase
    end

    assign gen_go   = (state_reg != ST_IDLE) && (!m_valid_reg || m_tready);
    assign gen_last = gen_end || (res_cnt_reg == CNT_FINAL)
                      || ((state_reg == ST_INIT) && (ROWS * (COLS + 5) == 0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            blank_reg      <= clcd_pkg::BLANK_RESET;
            device_reg     <= clcd_pkg::DEV_RESET;
            step_reg       <= '0;
            seq_row_reg    <= '0;
            tgt_row_reg    <= '0;
            tgt_col_reg    <= '0;
            do_cell_reg    <= 1'b0;
            res_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
            out_byte_reg   <= '0;
            out_cell_reg   <= 1'b0;
            out_start_reg  <= 1'b0;
            out_stop_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (clcd_pkg::cfg_reg_t'(cfg_index))
                    clcd_pkg::REG_BLANK:  blank_reg  <= cfg_data;
                    clcd_pkg::REG_DEVICE: device_reg <= cfg_data;
                    default:              blank_reg  <= blank_reg;
                endcase
            end

            if (gen_go) begin
                m_valid_reg   <= 1'b1;
                out_byte_reg  <= gen_byte;
                out_cell_reg  <= gen_cell;
                out_start_reg <= gen_start;
                out_stop_reg  <= gen_stop;
                out_last_reg  <= gen_last;
                res_cnt_reg   <= res_cnt_reg + CNT_W'(1);
                if (gen_last) begin
                    state_reg <= ST_IDLE;
                end else if (state_reg == ST_INIT && step_reg == STEP_HDR) begin
                    state_reg   <= ST_REFRESH;
                    step_reg    <= '0;
                    seq_row_reg <= '0;
                end else if (state_reg == ST_REFRESH && step_reg == STEP_END) begin
                    step_reg <= '0;
                    if (seq_row_reg == ROW_W'(ROWS - 1)) begin
                        state_reg   <= ST_CELL;
                        seq_row_reg <= tgt_row_reg;
                    end else begin
                        seq_row_reg <= seq_row_reg + ROW_W'(1);
                    end
                end else begin
                    step_reg <= step_reg + STEP_W'(1);
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            if (in_accept) begin
                res_cnt_reg <= '0;
                step_reg    <= '0;
                seq_row_reg <= '0;
                do_cell_reg <= 1'b0;
                unique case (in_action)
                    clcd_pkg::ACT_INIT: begin
                        state_reg      <= ST_INIT;
                        cursor_row_reg <= '0;
                        cursor_col_reg <= '0;
                    end
                    clcd_pkg::ACT_CLEAR: begin
                        cursor_row_reg <= '0;
                        cursor_col_reg <= '0;
                    end
                    clcd_pkg::ACT_GOTO: begin
                        if (in_range) begin
                            cursor_row_reg <= ROW_W'(in_row);
                            cursor_col_reg <= COL_W'(in_col);
                        end
                    end
                    clcd_pkg::ACT_PRINT: begin
                        if (cursor_col_reg == COL_W'(COLS - 1)) begin
                            cursor_col_reg <= '0;
                            cursor_row_reg <= (cursor_row_reg == ROW_W'(ROWS - 1)) ? '0
                                              : cursor_row_reg + ROW_W'(1);
                        end else begin
                            cursor_col_reg <= cursor_col_reg + COL_W'(1);
                        end
                        if (s_tlast) begin
                            state_reg <= ST_REFRESH;
                        end
                    end
                    clcd_pkg::ACT_RAW: begin
                        if (in_range) begin
                            state_reg   <= ST_REFRESH;
                            do_cell_reg <= 1'b1;
                            tgt_row_reg <= ROW_W'(in_row);
                            tgt_col_reg <= COL_W'(in_col);
                        end
                    end
                    default: begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb begin
        st_clr     = in_accept && (in_action == clcd_pkg::ACT_INIT
                                   || in_action == clcd_pkg::ACT_CLEAR);
        st_wr_en   = in_accept && (in_action == clcd_pkg::ACT_PRINT
                                   || (in_action == clcd_pkg::ACT_RAW && in_range));
        st_wr_addr = (in_action == clcd_pkg::ACT_PRINT) ? cursor_addr : target_addr;
        st_wr_data = (in_action == clcd_pkg::ACT_PRINT)
                     ? clcd_pkg::map_char(in_char, blank_reg) : in_char;
    end

    clcd_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clr       (st_clr),
        .clr_value (blank_reg),
        .wr_en     (st_wr_en),
        .wr_addr   (st_wr_addr),
        .wr_data   (st_wr_data),
        .rd_en     (gen_go && gen_cell),
        .rd_addr   (gen_addr),
        .rd_data   (st_rd_data)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_cell_reg ? st_rd_data : out_byte_reg;
    assign m_tuser  = {out_stop_reg, out_start_reg};
    assign m_tlast  = out_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        res_cnt_reg <= CNT_W'(clcd_pkg::MAX_RESULTS))
        else $error("result count passed its limit");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (gen_go && gen_last) |=> (state_reg == ST_IDLE))
        else $error("sequencer kept running after the final byte");

    a_no_write_during_read: assert property (@(posedge aclk) disable iff (!aresetn)
        !(st_wr_en && gen_go && gen_cell))
        else $error("store write overlapped a refresh read");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(cursor_row_reg) < ROWS) && (int'(cursor_col_reg) < COLS))
        else $error("cursor left the screen");

endmodule
